// ===== hw/rtl/kpc_pkg.sv =====
// Shared constants, types and key decode for the key press classifier.
package kpc_pkg;

	localparam int ScanW   = 8;
	localparam int HeldW   = 5;
	localparam int RelW    = 3;
	localparam int LockW   = 4;
	localparam int BeepW   = 4;
	localparam int IndexW  = 3;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 5;

	localparam logic [ScanW-1:0] NO_KEY = 8'hFF;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ENABLE  = 3'd0,
		CFG_SHORT   = 3'd1,
		CFG_LONG    = 3'd2,
		CFG_RELEASE = 3'd3,
		CFG_LOCKOUT = 3'd4,
		CFG_BEEP    = 3'd5
	} cfg_idx_t;

	localparam logic             RST_ENABLE  = 1'b0;
	localparam logic [HeldW-1:0] RST_SHORT   = 5'd2;
	localparam logic [HeldW-1:0] RST_LONG    = 5'd20;
	localparam logic [RelW-1:0]  RST_RELEASE = 3'd2;
	localparam logic [LockW-1:0] RST_LOCKOUT = 4'd10;
	localparam logic [BeepW-1:0] RST_BEEP    = 4'd10;

	typedef struct packed {
		logic              hit;
		logic [IndexW-1:0] index;
	} key_dec_t;

	function automatic key_dec_t key_number(input logic [ScanW-1:0] pat);
		key_dec_t d;
		d.hit   = 1'b1;
		d.index = '0;
		case (pat)
			8'hEF: d.index = 3'd0;
			8'hDF: d.index = 3'd1;
			8'hBF: d.index = 3'd2;
			8'h7F: d.index = 3'd3;
			8'hFE: d.index = 3'd4;
			8'hFD: d.index = 3'd5;
			8'hFB: d.index = 3'd6;
			8'hF7: d.index = 3'd7;
			default: d.hit = 1'b0;
		endcase
		return d;
	endfunction

endpackage

// ===== hw/rtl/key_press_classifier.sv =====
// Top level: scan-period key press classifier with short/long detection and beep.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | scan_code
//  out     | out_valid / out_ready | key_event, key_index, long_press, beep
//  cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One beat per cycle unless out_ready stalls, via the input and the result register.
// State update is one short combinational step on the input register.
// Reset clears all counters and handshake valids and the config registers to defaults.
// A stalled result holds the input register; in_ready drops only when both are full.
module key_press_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [kpc_pkg::ScanW-1:0]    scan_code,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         key_event,
	output logic [kpc_pkg::IndexW-1:0]   key_index,
	output logic                         long_press,
	output logic                         beep,
	input  logic                         cfg_we,
	input  logic [kpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kpc_pkg::CfgW-1:0]     cfg_data
);
	import kpc_pkg::*;

	logic             enable_q;
	logic [HeldW-1:0] short_q, long_q;
	logic [RelW-1:0]  release_q;
	logic [LockW-1:0] lockout_q;
	logic [BeepW-1:0] beep_per_q;

	logic [HeldW-1:0] held_q;
	logic [RelW-1:0]  rel_cnt_q;
	logic [ScanW-1:0] pattern_q;
	logic [LockW-1:0] lock_cnt_q;
	logic [BeepW-1:0] beep_cnt_q;
	logic             beep_lvl_q;

	logic              valid_s1;
	logic [ScanW-1:0]  scan_s1;
	logic              valid_s2;
	logic              event_s2;
	logic [IndexW-1:0] index_s2;
	logic              long_s2;
	logic              beep_s2;

	logic out_free, adv;

	assign out_free = !valid_s2 || out_ready;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= RST_ENABLE;
			short_q    <= RST_SHORT;
			long_q     <= RST_LONG;
			release_q  <= RST_RELEASE;
			lockout_q  <= RST_LOCKOUT;
			beep_per_q <= RST_BEEP;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:  enable_q   <= cfg_data[0];
				CFG_SHORT:   short_q    <= cfg_data[HeldW-1:0];
				CFG_LONG:    long_q     <= cfg_data[HeldW-1:0];
				CFG_RELEASE: release_q  <= cfg_data[RelW-1:0];
				CFG_LOCKOUT: lockout_q  <= cfg_data[LockW-1:0];
				CFG_BEEP:    beep_per_q <= cfg_data[BeepW-1:0];
				default: ;
			endcase
		end
	end

	// one period of the classifier
	logic [ScanW-1:0]  scan;
	logic [HeldW:0]    held_inc;
	logic [RelW:0]     rel_inc;
	logic [RelW-1:0]   need;
	key_dec_t          dec;
	logic [HeldW-1:0]  held_d;
	logic [RelW-1:0]   rel_d;
	logic [ScanW-1:0]  pattern_d;
	logic [LockW-1:0]  lock_d;
	logic [BeepW-1:0]  beep_cnt_d;
	logic              beep_lvl_d;
	logic              ev_d;
	logic [IndexW-1:0] idx_d;
	logic              lng_d;

	always_comb begin
		scan       = enable_q ? scan_s1 : NO_KEY;
		held_d     = held_q;
		rel_d      = rel_cnt_q;
		pattern_d  = pattern_q;
		lock_d     = lock_cnt_q;
		ev_d       = 1'b0;
		idx_d      = '0;
		lng_d      = 1'b0;
		beep_lvl_d = (beep_cnt_q == BeepW'(1)) ? 1'b0 : beep_lvl_q;
		beep_cnt_d = (beep_cnt_q != '0) ? beep_cnt_q - BeepW'(1) : beep_cnt_q;
		held_inc   = {1'b0, held_q} + (HeldW+1)'(1);
		rel_inc    = {1'b0, rel_cnt_q} + (RelW+1)'(1);
		need       = (release_q != '0) ? release_q : RelW'(1);
		dec        = key_number(pattern_q);
		if (scan != NO_KEY) begin
			pattern_d = scan;
			rel_d     = '0;
			held_d    = (held_inc > {1'b0, long_q}) ? long_q : held_inc[HeldW-1:0];
		end else if (rel_inc >= {1'b0, need}) begin
			rel_d = need;
			if (lock_cnt_q != '0) begin
				lock_d = lock_cnt_q - LockW'(1);
				held_d = '0;
			end else if (held_q >= short_q) begin
				if (dec.hit) begin
					ev_d       = 1'b1;
					idx_d      = dec.index;
					lng_d      = (held_q == long_q);
					beep_lvl_d = (beep_per_q != '0);
					beep_cnt_d = beep_per_q;
					lock_d     = lockout_q;
				end
				held_d = '0;
			end
		end else begin
			rel_d = rel_inc[RelW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			rel_cnt_q  <= '0;
			pattern_q  <= '0;
			lock_cnt_q <= '0;
			beep_cnt_q <= '0;
			beep_lvl_q <= 1'b0;
		end else if (adv) begin
			held_q     <= held_d;
			rel_cnt_q  <= rel_d;
			pattern_q  <= pattern_d;
			lock_cnt_q <= lock_d;
			beep_cnt_q <= beep_cnt_d;
			beep_lvl_q <= beep_lvl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (out_free) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) scan_s1 <= scan_code;
		if (adv) begin
			event_s2 <= ev_d;
			index_s2 <= idx_d;
			long_s2  <= lng_d;
			beep_s2  <= beep_lvl_d;
		end
	end

	assign out_valid  = valid_s2;
	assign key_event  = event_s2;
	assign key_index  = index_s2;
	assign long_press = long_s2;
	assign beep       = beep_s2;

endmodule

// ===== hw/rtl/kpc_checker.sv =====
// Port-level checks for the key press classifier, bound to the top level.
module kpc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        key_event,
	input logic [kpc_pkg::IndexW-1:0]  key_index,
	input logic                        long_press,
	input logic                        beep
);
	import kpc_pkg::*;

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_event |-> key_index == '0 && !long_press)
		else $error("index or long flag set without a key event");

	a_rise_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an input beat two cycles before");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_event) && $stable(key_index)
			&& $stable(long_press) && $stable(beep))
		else $error("stalled result beat changed");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register empty");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.key_event  (key_event),
	.key_index  (key_index),
	.long_press (long_press),
	.beep       (beep)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for key_press_classifier: directed scan table, then random press runs.
`timescale 1ns / 1ps

module tb_top;
	import kpc_pkg::*;

	localparam int ITEMS = 1950;

	typedef struct packed {
		logic              key_event;
		logic [IndexW-1:0] key_index;
		logic              long_press;
		logic              beep;
	} press_t;

	typedef enum logic {ROW_SCAN, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_idx_t         reg_sel;
		logic [ScanW-1:0] value;
		logic             typed;
		press_t           want;
	} row_t;

	localparam press_t QUIET = '0;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ScanW-1:0]    scan_code = NO_KEY;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                key_event;
	logic [IndexW-1:0]   key_index;
	logic                long_press;
	logic                beep;
	logic                cfg_we = 1'b0;
	cfg_idx_t            cfg_index = CFG_ENABLE;
	logic [CfgW-1:0]     cfg_data = '0;

	// register copies
	logic       set_enable = 1'b0;
	logic [4:0] set_short = 5'd2;
	logic [4:0] set_long = 5'd20;
	logic [2:0] set_release = 3'd2;
	logic [3:0] set_lockout = 4'd10;
	logic [3:0] set_beep = 4'd10;

	// classifier state
	logic [4:0] held_cnt = '0;
	logic [2:0] rel_cnt = '0;
	logic [7:0] last_pat = '0;
	logic [3:0] lock_cnt = '0;
	logic [3:0] beep_cnt = '0;
	logic       beep_lvl = 1'b0;

	logic [7:0] key_pat [8] = '{8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'hFE, 8'hFD, 8'hFB, 8'hF7};

	press_t pending_press [$];
	press_t want_press;
	int     fail_count = 0;
	int     beat_no = 0;
	int     items_sent = 0;
	int     counted = 0;
	bit     quiet_tail = 1'b0;

	row_t plan [33] = '{
		'{ROW_SCAN, CFG_ENABLE, 8'h00, 1'b1, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hEF, 1'b1, QUIET},
		'{ROW_REG, CFG_ENABLE, 8'd1, 1'b0, QUIET},
		'{ROW_REG, CFG_LOCKOUT, 8'd0, 1'b0, QUIET},
		'{ROW_REG, CFG_BEEP, 8'd3, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hEF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hEF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b1}},
		// hold too short, then topped up by the next press
		'{ROW_SCAN, CFG_ENABLE, 8'hFE, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFE, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b1, '{1'b1, 3'd4, 1'b0, 1'b1}},
		'{ROW_REG, CFG_SHORT, 8'd1, 1'b0, QUIET},
		'{ROW_REG, CFG_LONG, 8'd2, 1'b0, QUIET},
		'{ROW_REG, CFG_RELEASE, 8'd1, 1'b0, QUIET},
		'{ROW_REG, CFG_BEEP, 8'd15, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hF7, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hF7, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b1, '{1'b1, 3'd7, 1'b1, 1'b1}},
		// multi-key hold: evaluated, nothing reported
		'{ROW_SCAN, CFG_ENABLE, 8'h00, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'h7F, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_REG, CFG_LOCKOUT, 8'd1, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hEF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hDF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hBF, 1'b0, QUIET},
		'{ROW_SCAN, CFG_ENABLE, 8'hFF, 1'b0, QUIET}
	};

	key_press_classifier uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_code  (scan_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_event  (key_event),
		.key_index  (key_index),
		.long_press (long_press),
		.beep       (beep),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic press_t classify_scan(input logic [7:0] raw);
		logic [7:0] s;
		int         h, r, need, slot;
		press_t     res;
		s = set_enable ? raw : NO_KEY;
		res = '0;
		slot = -1;
		if (beep_cnt == 4'd1) beep_lvl = 1'b0;
		if (beep_cnt != 4'd0) beep_cnt--;
		if (s != NO_KEY) begin
			h = held_cnt + 1;
			last_pat = s;
			rel_cnt = '0;
			if (h > set_long) h = set_long;
			held_cnt = h[4:0];
		end else begin
			r = rel_cnt + 1;
			need = (set_release != 0) ? set_release : 1;
			if (r >= need) begin
				rel_cnt = need[2:0];
				if (lock_cnt != 4'd0) begin
					lock_cnt--;
					held_cnt = '0;
				end else if (held_cnt >= set_short) begin
					for (int k = 0; k < 8; k++) begin
						if (key_pat[k] == last_pat) slot = k;
					end
					if (slot >= 0) begin
						res.key_event = 1'b1;
						res.key_index = slot[2:0];
						res.long_press = (held_cnt == set_long);
						beep_lvl = (set_beep != 4'd0);
						beep_cnt = set_beep;
						lock_cnt = set_lockout;
					end
					held_cnt = '0;
				end
			end else begin
				rel_cnt = r[2:0];
			end
		end
		res.beep = beep_lvl;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t mismatch at result %0d: %s", $time, beat_no, what);
	endtask

	task automatic write_reg(input cfg_idx_t sel, input int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = value[4:0];
		case (sel)
			CFG_ENABLE:  set_enable = value[0];
			CFG_SHORT:   set_short = value[4:0];
			CFG_LONG:    set_long = value[4:0];
			CFG_RELEASE: set_release = value[2:0];
			CFG_LOCKOUT: set_lockout = value[3:0];
			CFG_BEEP:    set_beep = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_scan(input logic [7:0] s, input bit typed = 1'b0,
			input press_t want = '0);
		press_t guess;
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		scan_code = s;
		do @(posedge clk); while (!in_ready);
		guess = classify_scan(s);
		pending_press.push_back(typed ? want : guess);
		items_sent++;
		if (set_enable) counted++;
		if (counted >= ITEMS - 250) quiet_tail = 1'b1;
	endtask

	// idle the sender until every pending result is back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_press.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic new_setting(input int p);
		int e, s, l, r, k, b;
		case (p)
			0: begin e = 1; s = 31; l = 31; r = 7; k = 15; b = 15; end
			1: begin e = 1; s = 1; l = 1; r = 1; k = 0; b = 0; end
			2: begin e = 1; s = 0; l = 0; r = 0; k = 3; b = 1; end
			3: begin e = 0; s = 2; l = 20; r = 2; k = 10; b = 10; end
			4: begin e = 1; s = 20; l = 5; r = 2; k = 0; b = 4; end
			default: begin
				e = ($urandom_range(0, 9) != 0);
				s = $urandom_range(1, 8);
				l = $urandom_range(s, 31);
				if ($urandom_range(0, 4) == 0) begin
					s = $urandom_range(0, 31);
					l = $urandom_range(0, 31);
				end
				r = $urandom_range(0, 7);
				k = $urandom_range(0, 15);
				b = $urandom_range(0, 15);
			end
		endcase
		drain();
		write_reg(CFG_SHORT, s);
		write_reg(CFG_LONG, l);
		write_reg(CFG_RELEASE, r);
		write_reg(CFG_LOCKOUT, k);
		write_reg(CFG_BEEP, b);
		write_reg(CFG_ENABLE, e);
	endtask

	// one hold of a pattern followed by a release run, or a burst of noise
	task automatic press_burst();
		int         pick, hold, gap, rel, lock;
		logic [7:0] pat;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			repeat ($urandom_range(1, 6)) send_scan(8'($urandom_range(0, 255)));
			return;
		end
		if (pick == 1) begin
			if ($urandom_range(0, 1) == 0) pat = 8'h00;
			else pat = 8'($urandom_range(0, 254));
		end else begin
			pat = key_pat[$urandom_range(0, 7)];
		end
		if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 35);
		else hold = $urandom_range(1, set_long + 2);
		for (int i = 0; i < hold; i++) begin
			if ($urandom_range(0, 19) == 0) pat = key_pat[$urandom_range(0, 7)];
			send_scan(pat);
		end
		rel = set_release;
		lock = set_lockout;
		if ($urandom_range(0, 1) == 0) gap = $urandom_range(0, rel + 2);
		else gap = $urandom_range(rel, rel + lock + 3);
		repeat (gap) send_scan(NO_KEY);
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beat_no++;
			if (pending_press.size() == 0) begin
				report_mismatch("result beat with no scan pending");
			end else begin
				want_press = pending_press.pop_front();
				if (key_event !== want_press.key_event)
					report_mismatch($sformatf("key_event got %b want %b",
						key_event, want_press.key_event));
				if (key_index !== want_press.key_index)
					report_mismatch($sformatf("key_index got %0d want %0d",
						key_index, want_press.key_index));
				if (long_press !== want_press.long_press)
					report_mismatch($sformatf("long_press got %b want %b",
						long_press, want_press.long_press));
				if (beep !== want_press.beep)
					report_mismatch($sformatf("beep got %b want %b", beep, want_press.beep));
			end
		end
	end

	initial begin
		int phase, budget;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				drain();
				write_reg(plan[i].reg_sel, plan[i].value);
			end else begin
				send_scan(plan[i].value, plan[i].typed, plan[i].want);
			end
		end

		phase = 0;
		while (counted < ITEMS) begin
			new_setting(phase);
			budget = items_sent + (set_enable ? 150 : 40);
			while (items_sent < budget && counted < ITEMS) press_burst();
			phase++;
		end

		drain();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== key_press_classifier.f =====
hw/rtl/kpc_pkg.sv
hw/rtl/key_press_classifier.sv
hw/rtl/kpc_checker.sv
sim/tb_top.sv
